// ===== rtl/hrw_pkg.sv =====
// ----------------------------------------------------------------------------
// hrw_pkg
// Shared types and constants for the hex ring walker: register indexes,
// ring side codes, sequencer states, fixed field widths and parameter defaults.
// ----------------------------------------------------------------------------
package hrw_pkg;

  // Fixed field widths
  localparam int CENTER_W   = 15;
  localparam int RADIUS_W   = 4;
  localparam int ORIGIN_W   = 15;
  localparam int MAPDIM_W   = 13;
  localparam int WALK_W     = 17;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  // Parameter defaults
  localparam int MAX_RADIUS_DEF = 10;
  localparam int COORD_BITS_DEF = 16;

  // Register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_ORIGIN_X   = 2'd0,
    REG_ORIGIN_Y   = 2'd1,
    REG_MAP_WIDTH  = 2'd2,
    REG_MAP_HEIGHT = 2'd3
  } reg_idx_t;

  // Ring sides in walk order
  typedef enum logic [2:0] {
    SIDE_SE = 3'd0,
    SIDE_S  = 3'd1,
    SIDE_SW = 3'd2,
    SIDE_NW = 3'd3,
    SIDE_N  = 3'd4,
    SIDE_NE = 3'd5
  } side_t;

  // Sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } state_t;

endpackage

// ===== rtl/hex_ring_walker_core.sv =====
// The first word of a ring is offered in the cycle after the input word is
// accepted. A ring of radius r gives 6*r words (one for r = 0) at one word
// per cycle while out_stall is low, through the shared step adders; the
// sequencer returns to idle before the next input word is taken. Reset
// (rst_n, synchronous) returns the sequencer to idle and the map registers
// to origin (0,0), width 1, height 0.
// ----------------------------------------------------------------------------
// hex_ring_walker_core
// Walks one ring of an odd-q offset hex grid around a center cell, emitting
// each cell with a flag that marks whether it lies in the map rectangle.
// ----------------------------------------------------------------------------
module hex_ring_walker_core #(
  parameter int MAX_RADIUS = hrw_pkg::MAX_RADIUS_DEF,
  parameter int COORD_BITS = hrw_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [hrw_pkg::CENTER_W-1:0]  in_center_x,
  input  logic signed [hrw_pkg::CENTER_W-1:0]  in_center_y,
  input  logic        [hrw_pkg::RADIUS_W-1:0]  in_ring_radius,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [COORD_BITS-1:0]         out_pos_x,
  output logic signed [COORD_BITS-1:0]         out_pos_y,
  output logic                                 out_in_map,
  output logic                                 out_last,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic        [hrw_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic        [hrw_pkg::CFG_DATA_W-1:0] pwdata,
  output logic        [hrw_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready
);
  import hrw_pkg::*;

  localparam logic [RADIUS_W-1:0] RAD_CAP = RADIUS_W'(MAX_RADIUS);
  localparam int CMP_W = WALK_W + 2;

  // Configuration registers
  logic signed [ORIGIN_W-1:0] origin_x_r;
  logic signed [ORIGIN_W-1:0] origin_y_r;
  logic        [MAPDIM_W-1:0] map_width_r;
  logic        [MAPDIM_W-1:0] map_height_r;

  // Walk state
  state_t                     state_r, state_nxt;
  logic signed [WALK_W-1:0]   walk_x_r, walk_x_nxt;
  logic signed [WALK_W-1:0]   walk_y_r, walk_y_nxt;
  side_t                      side_r, side_nxt;
  logic        [RADIUS_W-1:0] step_r, step_nxt;
  logic        [RADIUS_W-1:0] radius_r, radius_nxt;

  logic                       in_acc;
  logic                       out_acc;
  logic                       cfg_wr;
  logic        [RADIUS_W-1:0] radius_cap;
  logic                       side_end;
  logic                       ring_last;
  logic signed [1:0]          dx;
  logic signed [1:0]          dy;
  logic signed [CMP_W-1:0]    rel_x;
  logic signed [CMP_W-1:0]    rel_y;
  reg_idx_t                   reg_idx;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r   <= '0;
      origin_y_r   <= '0;
      map_width_r  <= MAPDIM_W'(1);
      map_height_r <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ORIGIN_X:   origin_x_r   <= pwdata[ORIGIN_W-1:0];
        REG_ORIGIN_Y:   origin_y_r   <= pwdata[ORIGIN_W-1:0];
        REG_MAP_WIDTH:  map_width_r  <= pwdata[MAPDIM_W-1:0];
        REG_MAP_HEIGHT: map_height_r <= pwdata[MAPDIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back registers, origins sign-extended
  always_comb begin
    case (reg_idx)
      REG_ORIGIN_X:   prdata = CFG_DATA_W'(origin_x_r);
      REG_ORIGIN_Y:   prdata = CFG_DATA_W'(origin_y_r);
      REG_MAP_WIDTH:  prdata = {{(CFG_DATA_W-MAPDIM_W){1'b0}}, map_width_r};
      REG_MAP_HEIGHT: prdata = {{(CFG_DATA_W-MAPDIM_W){1'b0}}, map_height_r};
      default:        prdata = '0;
    endcase
  end

  // Saturate the requested radius
  assign radius_cap = (in_ring_radius > RAD_CAP) ? RAD_CAP : in_ring_radius;

  // Position within the ring
  assign side_end  = (step_r == radius_r - RADIUS_W'(1));
  assign ring_last = (radius_r == '0) || ((side_r == SIDE_NE) && side_end);

  // Step direction for the current side; parity from the absolute column
  always_comb begin
    case (side_r)
      SIDE_SE: begin dx = 2'sd1;  dy = walk_x_r[0] ? 2'sd1 : 2'sd0;  end
      SIDE_S:  begin dx = 2'sd0;  dy = 2'sd1;                          end
      SIDE_SW: begin dx = -2'sd1; dy = walk_x_r[0] ? 2'sd1 : 2'sd0;  end
      SIDE_NW: begin dx = -2'sd1; dy = walk_x_r[0] ? 2'sd0 : -2'sd1; end
      SIDE_N:  begin dx = 2'sd0;  dy = -2'sd1;                         end
      SIDE_NE: begin dx = 2'sd1;  dy = walk_x_r[0] ? 2'sd0 : -2'sd1; end
      default: begin dx = 2'sd0;  dy = 2'sd0;                          end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_EMIT;
      ST_EMIT: if (out_acc && ring_last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Load the start cell or advance one step through the shared step adders
  always_comb begin
    walk_x_nxt = walk_x_r;
    walk_y_nxt = walk_y_r;
    side_nxt   = side_r;
    step_nxt   = step_r;
    radius_nxt = radius_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          walk_x_nxt = WALK_W'(in_center_x);
          walk_y_nxt = WALK_W'(in_center_y) - WALK_W'(radius_cap);
          side_nxt   = SIDE_SE;
          step_nxt   = '0;
          radius_nxt = radius_cap;
        end
      end
      ST_EMIT: begin
        if (out_acc && !ring_last) begin
          walk_x_nxt = walk_x_r + WALK_W'(dx);
          walk_y_nxt = walk_y_r + WALK_W'(dy);
          if (side_end) begin
            step_nxt = '0;
            side_nxt = side_t'(side_r + 3'd1);
          end else begin
            step_nxt = step_r + RADIUS_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Hold sequencer and walk registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      side_r   <= SIDE_SE;
      step_r   <= '0;
      radius_r <= '0;
      walk_x_r <= '0;
      walk_y_r <= '0;
    end else begin
      state_r  <= state_nxt;
      side_r   <= side_nxt;
      step_r   <= step_nxt;
      radius_r <= radius_nxt;
      walk_x_r <= walk_x_nxt;
      walk_y_r <= walk_y_nxt;
    end
  end

  // Map rectangle test on the current cell
  assign rel_x = CMP_W'(walk_x_r) - CMP_W'(origin_x_r);
  assign rel_y = CMP_W'(walk_y_r) - CMP_W'(origin_y_r);

  // Handshake and result words
  always_comb begin
    in_stall   = (state_r != ST_IDLE);
    out_valid  = (state_r == ST_EMIT);
    out_pos_x  = COORD_BITS'(walk_x_r);
    out_pos_y  = COORD_BITS'(walk_y_r);
    out_last   = ring_last;
    out_in_map = !rel_x[CMP_W-1] && !rel_y[CMP_W-1] &&
                 (rel_x < $signed({{(CMP_W-MAPDIM_W){1'b0}}, map_width_r})) &&
                 (rel_y < $signed({{(CMP_W-MAPDIM_W){1'b0}}, map_height_r}));
  end

endmodule

// ===== sim/hex_ring_walker_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hex_ring_walker_check
// Watches the input, result and register channels of the hex ring walker.
// Every accepted input word is expanded into the ring cells it should give,
// and every accepted result word is checked against the oldest cell due.
// ----------------------------------------------------------------------------
module hex_ring_walker_check (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  input  logic                                    in_stall,
  input  logic signed [hrw_pkg::CENTER_W-1:0]     in_center_x,
  input  logic signed [hrw_pkg::CENTER_W-1:0]     in_center_y,
  input  logic        [hrw_pkg::RADIUS_W-1:0]     in_ring_radius,
  input  logic                                    out_valid,
  input  logic                                    out_stall,
  input  logic signed [hrw_pkg::COORD_BITS_DEF-1:0] out_pos_x,
  input  logic signed [hrw_pkg::COORD_BITS_DEF-1:0] out_pos_y,
  input  logic                                    out_in_map,
  input  logic                                    out_last,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic                                    pready,
  input  logic        [hrw_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic        [hrw_pkg::CFG_DATA_W-1:0]   pwdata,
  output int                                      err_count,
  output int                                      cells_due
);
  import hrw_pkg::*;

  localparam int POS_W    = COORD_BITS_DEF;
  localparam int RING_MAX = MAX_RADIUS_DEF;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    in_map;
    logic                    last;
  } ring_cell_t;

  ring_cell_t ring_cells_due[$];
  ring_cell_t want_cell;
  ring_cell_t seen_cell;

  // shadow copy of the map registers
  int org_x, org_y, map_w, map_h;

  // build one cell word, flagging whether it falls in the map rectangle
  function automatic ring_cell_t make_cell(int x, int y, logic is_last);
    ring_cell_t c;
    int dx, dy;
    dx = x - org_x;
    dy = y - org_y;
    c.pos_x  = x[POS_W-1:0];
    c.pos_y  = y[POS_W-1:0];
    c.in_map = (dx >= 0) && (dy >= 0) && (dx < map_w) && (dy < map_h);
    c.last   = is_last;
    return c;
  endfunction

  // append one cell at the tail of the queue
  task automatic add_due(ring_cell_t c);
    ring_cells_due.insert(ring_cells_due.size(), c);
  endtask

  // expand one ring into the queue of cells due, in walk order
  task automatic walk_ring_cells(int cx, int cy, int radius);
    int   wx, wy, n, total;
    logic odd;
    if (radius > RING_MAX) radius = RING_MAX;
    if (radius == 0) begin
      add_due(make_cell(cx, cy, 1'b1));
      return;
    end
    total = 6 * radius;
    n     = 0;
    wx    = cx;
    wy    = cy - radius;
    for (int s = SIDE_SE; s <= SIDE_NE; s++) begin
      for (int k = 0; k < radius; k++) begin
        n++;
        add_due(make_cell(wx, wy, n == total));
        // column parity decides whether a diagonal step also shifts the row
        odd = wx[0];
        case (side_t'(s))
          SIDE_SE: begin
            if (odd) wy++;
            wx++;
          end
          SIDE_S:  wy++;
          SIDE_SW: begin
            if (odd) wy++;
            wx--;
          end
          SIDE_NW: begin
            if (!odd) wy--;
            wx--;
          end
          SIDE_N:  wy--;
          default: begin
            if (!odd) wy--;
            wx++;
          end
        endcase
      end
    end
  endtask

  task automatic report_bad(string what);
    err_count++;
    if (err_count <= 10) begin
      $display("%0t: %s: want x=%0d y=%0d map=%0b last=%0b, got x=%0d y=%0d map=%0b last=%0b",
               $realtime, what, want_cell.pos_x, want_cell.pos_y, want_cell.in_map,
               want_cell.last, seen_cell.pos_x, seen_cell.pos_y, seen_cell.in_map,
               seen_cell.last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      org_x = 0;
      org_y = 0;
      map_w = 1;
      map_h = 0;
      ring_cells_due.delete();
    end else begin
      // track register writes
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[CFG_ADDR_W-1:2]))
          REG_ORIGIN_X:   org_x = int'($signed(pwdata[ORIGIN_W-1:0]));
          REG_ORIGIN_Y:   org_y = int'($signed(pwdata[ORIGIN_W-1:0]));
          REG_MAP_WIDTH:  map_w = int'(pwdata[MAPDIM_W-1:0]);
          REG_MAP_HEIGHT: map_h = int'(pwdata[MAPDIM_W-1:0]);
          default: ;
        endcase
      end
      // check result words against the oldest cell due
      if (out_valid && !out_stall) begin
        seen_cell = '{out_pos_x, out_pos_y, out_in_map, out_last};
        if (ring_cells_due.size() == 0) begin
          want_cell = 'x;
          report_bad("unexpected cell");
        end else begin
          want_cell = ring_cells_due.pop_front();
          if (seen_cell !== want_cell) report_bad("cell mismatch");
        end
      end
      // expand accepted input words
      if (in_valid && !in_stall) begin
        walk_ring_cells(int'(in_center_x), int'(in_center_y), int'(in_ring_radius));
      end
    end
    cells_due <= ring_cells_due.size();
  end

endmodule

// ===== sim/hex_ring_walker_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hex_ring_walker_core_test
// Drives ring requests and map settings into the hex ring walker with random
// gaps and result stalls; a separate checker predicts and compares every cell.
// ----------------------------------------------------------------------------
module hex_ring_walker_core_test;
  import hrw_pkg::*;

  logic                           clk            = 1'b0;
  logic                           rst_n          = 1'b0;
  logic                           in_valid       = 1'b0;
  logic                           in_stall;
  logic signed [CENTER_W-1:0]     in_center_x    = '0;
  logic signed [CENTER_W-1:0]     in_center_y    = '0;
  logic        [RADIUS_W-1:0]     in_ring_radius = '0;
  logic                           out_valid;
  logic                           out_stall      = 1'b0;
  logic signed [COORD_BITS_DEF-1:0] out_pos_x;
  logic signed [COORD_BITS_DEF-1:0] out_pos_y;
  logic                           out_in_map;
  logic                           out_last;
  logic                           psel           = 1'b0;
  logic                           penable        = 1'b0;
  logic                           pwrite         = 1'b0;
  logic        [CFG_ADDR_W-1:0]   paddr          = '0;
  logic        [CFG_DATA_W-1:0]   pwdata         = '0;
  logic        [CFG_DATA_W-1:0]   prdata;
  logic                           pready;

  int   err_count;
  int   cells_due;
  int   stall_run = 0;
  int   mode_run  = 0;
  logic calm_out  = 1'b0;
  logic calm_in   = 1'b0;

  hex_ring_walker_core i_dut (.*);

  hex_ring_walker_check i_check (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  function automatic int pick_dim();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 0;
    if (p < 7) return $urandom_range(1, 24);
    if (p < 9) return $urandom_range(25, 4096);
    return $urandom_range(4097, 8191);
  endfunction

  function automatic int clamp_coord(int v);
    if (v < -16384) return -16384;
    if (v > 16383) return 16383;
    return v;
  endfunction

  // stall the result side in runs, with quiet stretches in between
  always @(posedge clk) begin
    if (mode_run == 0) begin
      calm_out = ($urandom_range(0, 4) == 0);
      mode_run = $urandom_range(50, 400);
    end else begin
      mode_run--;
    end
    if (stall_run == 0 && !calm_out && $urandom_range(0, 3) == 0) stall_run = pick_gap();
    out_stall <= (stall_run != 0);
    if (stall_run != 0) stall_run--;
  end

  // one register write: setup cycle, access cycle, then release the bus
  task automatic cfg_write(reg_idx_t idx, int val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // drop valid and hold until every cell due has come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (cells_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_map(int ox, int oy, int w, int h);
    wait_idle();
    cfg_write(REG_ORIGIN_X, ox);
    cfg_write(REG_ORIGIN_Y, oy);
    cfg_write(REG_MAP_WIDTH, w);
    cfg_write(REG_MAP_HEIGHT, h);
  endtask

  // offer one ring request word after an optional gap, hold until taken
  task automatic send_ring(int cx, int cy, int r, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_center_x    <= CENTER_W'(cx);
    in_center_y    <= CENTER_W'(cy);
    in_ring_radius <= RADIUS_W'(r);
    do @(posedge clk); while (in_stall);
  endtask

  initial begin : stim
    int ox, oy, w, h, cx, cy, r, span_w, span_h;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset map has no rows, so nothing lands in it
    send_ring(0, 0, 1, 0);
    send_ring(1, 1, 0, 0);

    // small map around the origin: every radius, even and odd columns
    set_map(-4, -4, 9, 9);
    for (int k = 0; k < 16; k++) send_ring(k - 8, (k % 3) - 1, k, pick_gap());
    send_ring(-16384, -16384, 10, 0);
    send_ring(16383, 16383, 15, 1);

    // map pinned at the low corner, largest nominal size
    set_map(-16384, -16384, 4096, 4096);
    send_ring(-16384, -16384, 10, 0);
    send_ring(-12289, -12289, 3, 0);

    // map pinned at the high corner, oversized
    set_map(16383, 16383, 8191, 8191);
    send_ring(16383, 16383, 10, 0);

    // empty maps: no columns, then no rows
    set_map(0, 0, 0, 50);
    send_ring(2, 2, 2, 0);
    set_map(0, 0, 50, 0);
    send_ring(2, 2, 2, 0);

    // random maps, rings mostly near the map edges
    for (int ph = 0; ph < 8; ph++) begin
      ox = $urandom_range(0, 32767) - 16384;
      oy = $urandom_range(0, 32767) - 16384;
      w  = pick_dim();
      h  = pick_dim();
      set_map(ox, oy, w, h);
      calm_in = ($urandom_range(0, 3) == 0);
      span_w  = (w < 40 ? w : 40) + 24;
      span_h  = (h < 40 ? h : 40) + 24;
      repeat (56) begin
        if ($urandom_range(0, 4) != 0) begin
          cx = clamp_coord(ox + int'($urandom_range(0, span_w)) - 12);
          cy = clamp_coord(oy + int'($urandom_range(0, span_h)) - 12);
        end else begin
          cx = $urandom_range(0, 32767) - 16384;
          cy = $urandom_range(0, 32767) - 16384;
        end
        r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 5);
        send_ring(cx, cy, r, calm_in ? 0 : pick_gap());
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hard stop if the walker hangs
  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/hrw_pkg.sv
rtl/hex_ring_walker_core.sv
sim/hex_ring_walker_check.sv
sim/hex_ring_walker_core_test.sv
